// ===== rtl/core/eptl_pkg.sv =====
// ----------------------------------------------------------------------------
// eptl_pkg
// Shared types and constants of the four-level translation table lookup.
// ----------------------------------------------------------------------------
package eptl_pkg;

    // Field widths
    localparam int unsigned GA_W    = 48;
    localparam int unsigned HA_W    = 52;
    localparam int unsigned FL_W    = 12;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned ENT_W   = 52;
    localparam int unsigned OFF_W   = 12;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned ENTRIES = 512;
    localparam int unsigned LINK_W  = ENT_W - OFF_W;

    // Flags of a non-leaf link entry
    localparam logic [OFF_W-1:0] LINK_FLAGS = 12'h007;

    // Level codes: the root is the highest
    localparam logic [1:0] LVL_ROOT = 2'd3;
    localparam logic [1:0] LVL_L3   = 2'd2;
    localparam logic [1:0] LVL_L2   = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    typedef enum logic [1:0] {
        CMD_MAP    = 2'd0,
        CMD_UNMAP  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ARG  = 2'd1,
        ST_NO_POOL  = 2'd2,
        ST_UNMAPPED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        WS_INIT,
        WS_IDLE,
        WS_READ,
        WS_EVAL,
        WS_ZERO,
        WS_DONE
    } t_walk_state;

    typedef struct packed {
        t_status           status;
        logic [HA_W-1:0]   translated_address;
        logic              was_mapped;
        logic [CNT_W-1:0]  mapped_page_count;
    } t_rsp;

endpackage

// ===== rtl/core/eptl_if.sv =====
// ----------------------------------------------------------------------------
// eptl_if
// Valid/ready channels for command items and response items.
// ----------------------------------------------------------------------------
interface eptl_cmd_if import eptl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [GA_W-1:0]   guest_address;
    logic [HA_W-1:0]   host_address;
    logic [FL_W-1:0]   entry_flags;

    modport source (output valid, command, guest_address, host_address, entry_flags,
                    input ready);
    modport sink   (input valid, command, guest_address, host_address, entry_flags,
                    output ready);
endinterface

interface eptl_rsp_if import eptl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [HA_W-1:0]   translated_address;
    logic              was_mapped;
    logic [CNT_W-1:0]  mapped_page_count;

    modport source (output valid, status, translated_address, was_mapped,
                    mapped_page_count, input ready);
    modport sink   (input valid, status, translated_address, was_mapped,
                    mapped_page_count, output ready);
endinterface

// ===== rtl/core/eptl_table_ram.sv =====
// ----------------------------------------------------------------------------
// eptl_table_ram
// Single-port table pool memory, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module eptl_table_ram import eptl_pkg::*; #(
    parameter  int unsigned DEPTH  = 32768,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [ENT_W-1:0]  i_wdata,
    output logic [ENT_W-1:0]  o_rdata
);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/eptl_walker.sv =====
// ----------------------------------------------------------------------------
// eptl_walker
// Table walk sequencer: reads one level per step, allocates and clears
// missing tables, writes leaves and keeps the page count.
// ----------------------------------------------------------------------------
module eptl_walker import eptl_pkg::*; #(
    parameter  int unsigned TABLE_POOL = 64,
    localparam int unsigned TBL_IDX_W  = $clog2(TABLE_POOL),
    localparam int unsigned ADDR_W     = TBL_IDX_W + IDX_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eptl_cmd_if.sink          i_cmd,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_addr,
    output logic [ENT_W-1:0]  o_ram_wdata,
    input  logic [ENT_W-1:0]  i_ram_rdata,
    output t_rsp              o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);

    localparam int unsigned NF_W = $clog2(TABLE_POOL + 1);

    t_walk_state          r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [GA_W-1:0]      r_gaddr, n_gaddr;
    logic [HA_W-1:0]      r_haddr, n_haddr;
    logic [FL_W-1:0]      r_flags, n_flags;
    logic [1:0]           r_lvl, n_lvl;
    logic [TBL_IDX_W-1:0] r_tbl, n_tbl;
    logic [NF_W-1:0]      r_next_free, n_next_free;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_clr_idx, n_clr_idx;
    t_status              r_status, n_status;
    logic [HA_W-1:0]      r_xlat, n_xlat;
    logic                 r_was, n_was;

    logic [IDX_W-1:0]     lvl_idx;
    logic [LINK_W-1:0]    link_tbl;
    logic                 follow_ok;
    logic                 pool_empty;
    logic                 clr_sel;
    logic                 bad_map;

    // Select the index of the current level
    always_comb begin
        unique case (r_lvl)
            LVL_ROOT: lvl_idx = r_gaddr[47:39];
            LVL_L3:   lvl_idx = r_gaddr[38:30];
            LVL_L2:   lvl_idx = r_gaddr[29:21];
            default:  lvl_idx = r_gaddr[20:12];
        endcase
    end

    // Decode the entry read back from the pool
    assign link_tbl   = i_ram_rdata[OFF_W +: LINK_W];
    assign follow_ok  = i_ram_rdata[0] && (link_tbl < LINK_W'(TABLE_POOL));
    assign pool_empty = (r_next_free >= NF_W'(TABLE_POOL));
    assign bad_map    = (i_cmd.guest_address[OFF_W-1:0] != '0)
                     || (i_cmd.host_address[OFF_W-1:0] != '0)
                     || !i_cmd.entry_flags[0];

    // Memory address: sweep counter while clearing, walk index otherwise
    assign clr_sel    = (r_state == WS_INIT) || (r_state == WS_ZERO);
    assign o_ram_addr = clr_sel ? {r_tbl, r_clr_idx} : {r_tbl, lvl_idx};

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_gaddr     = r_gaddr;
        n_haddr     = r_haddr;
        n_flags     = r_flags;
        n_lvl       = r_lvl;
        n_tbl       = r_tbl;
        n_next_free = r_next_free;
        n_count     = r_count;
        n_clr_idx   = r_clr_idx;
        n_status    = r_status;
        n_xlat      = r_xlat;
        n_was       = r_was;
        o_ram_we    = 1'b0;
        o_ram_wdata = '0;
        i_cmd.ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            // Clear the root table after reset
            WS_INIT: begin
                o_ram_we  = 1'b1;
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(ENTRIES - 1)) begin
                    n_state = WS_IDLE;
                end
            end

            // Take a new item
            WS_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_cmd    = t_cmd'(i_cmd.command);
                    n_gaddr  = i_cmd.guest_address;
                    n_haddr  = i_cmd.host_address;
                    n_flags  = i_cmd.entry_flags;
                    n_lvl    = LVL_ROOT;
                    n_tbl    = '0;
                    n_status = ST_OK;
                    n_xlat   = '0;
                    n_was    = 1'b0;
                    priority if (t_cmd'(i_cmd.command) == CMD_RSVD) begin
                        n_state = WS_DONE;
                    end else if (t_cmd'(i_cmd.command) == CMD_MAP && bad_map) begin
                        n_status = ST_BAD_ARG;
                        n_state  = WS_DONE;
                    end else begin
                        n_state = WS_READ;
                    end
                end
            end

            // Present the entry address; data returns next cycle
            WS_READ: begin
                n_state = WS_EVAL;
            end

            // Act on the entry of the current level
            WS_EVAL: begin
                if (r_lvl != LVL_LEAF) begin
                    priority if (follow_ok) begin
                        n_tbl   = link_tbl[TBL_IDX_W-1:0];
                        n_lvl   = r_lvl - 2'd1;
                        n_state = WS_READ;
                    end else if (r_cmd != CMD_MAP) begin
                        n_status = ST_UNMAPPED;
                        n_state  = WS_DONE;
                    end else if (pool_empty) begin
                        n_status = ST_NO_POOL;
                        n_state  = WS_DONE;
                    end else begin
                        // Link a fresh table, then clear it
                        o_ram_we    = 1'b1;
                        o_ram_wdata = {LINK_W'(r_next_free), LINK_FLAGS};
                        n_tbl       = r_next_free[TBL_IDX_W-1:0];
                        n_next_free = r_next_free + NF_W'(1);
                        n_lvl       = r_lvl - 2'd1;
                        n_clr_idx   = '0;
                        n_state     = WS_ZERO;
                    end
                end else begin
                    n_state = WS_DONE;
                    unique case (r_cmd)
                        CMD_MAP: begin
                            o_ram_we    = 1'b1;
                            o_ram_wdata = {r_haddr[HA_W-1:OFF_W], r_flags};
                            if (i_ram_rdata[0]) begin
                                n_was = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_UNMAP: begin
                            if (i_ram_rdata[0]) begin
                                o_ram_we = 1'b1;
                                n_count  = r_count - CNT_W'(1);
                            end else begin
                                n_status = ST_UNMAPPED;
                            end
                        end
                        default: begin
                            if (i_ram_rdata[0]) begin
                                n_xlat = {i_ram_rdata[ENT_W-1:OFF_W], r_gaddr[OFF_W-1:0]};
                            end else begin
                                n_status = ST_UNMAPPED;
                            end
                        end
                    endcase
                end
            end

            // Sweep a newly linked table to zero, then continue the walk
            WS_ZERO: begin
                o_ram_we  = 1'b1;
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(ENTRIES - 1)) begin
                    n_state = WS_READ;
                end
            end

            // Hand the result to the output stage
            WS_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = WS_IDLE;
                end
            end

            default: begin
                n_state = WS_INIT;
            end
        endcase
    end

    assign o_res = '{status:             r_status,
                     translated_address: r_xlat,
                     was_mapped:         r_was,
                     mapped_page_count:  r_count};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= WS_INIT;
            r_tbl       <= '0;
            r_clr_idx   <= '0;
            r_next_free <= NF_W'(1);
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_tbl       <= n_tbl;
            r_clr_idx   <= n_clr_idx;
            r_next_free <= n_next_free;
            r_count     <= n_count;
        end
    end

    // Item payload and result fields
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_gaddr  <= n_gaddr;
        r_haddr  <= n_haddr;
        r_flags  <= n_flags;
        r_lvl    <= n_lvl;
        r_status <= n_status;
        r_xlat   <= n_xlat;
        r_was    <= n_was;
    end

endmodule

// ===== rtl/core/ept_four_level_map_unmap_lookup.sv =====
// ----------------------------------------------------------------------------
// ept_four_level_map_unmap_lookup
// Four-level guest-to-host translation tree with map, unmap and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries command items (map, unmap, lookup) with guest address,
//   host page address and leaf flags. o_rsp carries one response item per
//   command: status, translated address, overwrite flag and page count.
//   Items are handled one at a time. Each level of the walk presents the
//   entry address, then acts on the registered read data from the
//   single-port table memory. Each table allocated during a map is
//   cleared, one entry per cycle. A map rejected by its checks, or an
//   unused command code, answers without a walk.
//   After reset the root table is swept to zero; i_cmd.ready stays low
//   during the sweep. The allocator then starts at table 1 and the page
//   count at zero.
//   A stalled o_rsp holds its item in the output register; the walker may
//   take and process the next item meanwhile, and holds its own result until
//   the output register frees up.
// ----------------------------------------------------------------------------
module ept_four_level_map_unmap_lookup import eptl_pkg::*; #(
    parameter int unsigned TABLE_POOL = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eptl_cmd_if.sink  i_cmd,
    eptl_rsp_if.source o_rsp
);

    localparam int unsigned DEPTH  = TABLE_POOL * ENTRIES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    t_rsp              res;
    logic              res_valid;
    logic              res_ready;

    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    eptl_table_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    eptl_walker #(
        .TABLE_POOL (TABLE_POOL)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready)
    );

    // Output register: load a finished item when empty or draining
    assign res_ready = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        n_rsp   = r_rsp;
        if (res_valid && res_ready) begin
            n_valid = 1'b1;
            n_rsp   = res;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid              = r_valid;
    assign o_rsp.status             = r_rsp.status;
    assign o_rsp.translated_address = r_rsp.translated_address;
    assign o_rsp.was_mapped         = r_rsp.was_mapped;
    assign o_rsp.mapped_page_count  = r_rsp.mapped_page_count;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level translation tree. A shadow copy of
// the tree, the table allocator and the page count predicts the answer to
// every accepted command item. The bench opens with hand-picked map, unmap
// and lookup items, then exhausts the table pool, then runs random traffic
// over pages that are mostly already known. Both channels idle in random
// bursts, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import eptl_pkg::*;

    localparam int unsigned POOL_TABLES = 64;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned TAIL_QUIET  = 80;
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE      = 50;
    localparam int unsigned FILL_MAPS   = 22;
    localparam int unsigned RAND_ITEMS  = 907;
    localparam int unsigned DRAIN_AT    = 450;

    typedef struct {
        t_cmd             command;
        logic [GA_W-1:0]  guest;
        logic [HA_W-1:0]  host;
        logic [FL_W-1:0]  flags;
        bit               drain_first;
    } t_page_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    eptl_cmd_if cmd_if ();
    eptl_rsp_if rsp_if ();

    ept_four_level_map_unmap_lookup #(
        .TABLE_POOL (POOL_TABLES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Command items waiting to be offered, and answers still owed
    t_page_cmd        cmd_backlog [$];
    t_rsp             answers_due [$];
    logic [GA_W-1:0]  known_pages [$];

    // Shadow tree: key is table * 512 + index, a missing key reads as zero
    logic [ENT_W-1:0] shadow_tree [int unsigned];
    int unsigned      next_table = 1;
    logic [CNT_W-1:0] shadow_pages = '0;

    int unsigned      cycle_cnt = 0;
    int unsigned      cmds_taken = 0;
    int unsigned      miscompare_cnt = 0;
    bit               cmd_took = 1'b0;
    int unsigned      tx_gap = 0;
    int unsigned      rx_gap = 0;
    int unsigned      tx_mode = 1;
    int unsigned      rx_mode = 1;
    int unsigned      hold_left = 0;
    bit               hold_done = 1'b0;

    function automatic int unsigned entry_key(int unsigned tbl, logic [GA_W-1:0] ga, int lvl);
        return tbl * ENTRIES + ga[OFF_W + IDX_W * (lvl - 1) +: IDX_W];
    endfunction

    function automatic logic [ENT_W-1:0] entry_at(int unsigned key);
        return shadow_tree.exists(key) ? shadow_tree[key] : '0;
    endfunction

    // Present link that names a table inside the pool
    function automatic bit link_valid(logic [ENT_W-1:0] ent);
        return ent[0] && (ent[ENT_W-1:OFF_W] < POOL_TABLES);
    endfunction

    // Walk down to the leaf slot without allocating; 0 when a level is missing
    function automatic bit find_leaf(logic [GA_W-1:0] ga, output int unsigned key);
        int unsigned      tbl;
        logic [ENT_W-1:0] ent;
        tbl = 0;
        key = 0;
        for (int lvl = 4; lvl > 1; lvl--) begin
            ent = entry_at(entry_key(tbl, ga, lvl));
            if (!link_valid(ent))
                return 1'b0;
            tbl = 32'(ent[ENT_W-1:OFF_W]);
        end
        key = entry_key(tbl, ga, 1);
        return 1'b1;
    endfunction

    // Apply one command to the shadow tree and return the answer it owes
    function automatic t_rsp tree_answer(t_page_cmd pc);
        t_rsp             ans;
        int unsigned      tbl;
        int unsigned      key;
        logic [ENT_W-1:0] ent;
        ans = '0;
        ans.status = ST_OK;
        tbl = 0;
        case (pc.command)
            CMD_MAP: begin
                if (pc.guest[OFF_W-1:0] != '0 || pc.host[OFF_W-1:0] != '0 || !pc.flags[0]) begin
                    ans.status = ST_BAD_ARG;
                end else begin
                    for (int lvl = 4; lvl > 1 && ans.status == ST_OK; lvl--) begin
                        key = entry_key(tbl, pc.guest, lvl);
                        ent = entry_at(key);
                        if (link_valid(ent)) begin
                            tbl = 32'(ent[ENT_W-1:OFF_W]);
                        end else if (next_table >= POOL_TABLES) begin
                            ans.status = ST_NO_POOL;
                        end else begin
                            // each table is handed out once, so it is still all zero
                            tbl = next_table;
                            next_table++;
                            shadow_tree[key] = {LINK_W'(tbl), LINK_FLAGS};
                        end
                    end
                    if (ans.status == ST_OK) begin
                        key = entry_key(tbl, pc.guest, 1);
                        ent = entry_at(key);
                        ans.was_mapped = ent[0];
                        if (!ent[0])
                            shadow_pages++;
                        shadow_tree[key] = {pc.host[HA_W-1:OFF_W], pc.flags};
                    end
                end
            end
            CMD_UNMAP, CMD_LOOKUP: begin
                if (!find_leaf(pc.guest, key)) begin
                    ans.status = ST_UNMAPPED;
                end else begin
                    ent = entry_at(key);
                    if (!ent[0]) begin
                        ans.status = ST_UNMAPPED;
                    end else if (pc.command == CMD_UNMAP) begin
                        shadow_tree[key] = '0;
                        shadow_pages--;
                    end else begin
                        ans.translated_address = {ent[ENT_W-1:OFF_W], pc.guest[OFF_W-1:0]};
                    end
                end
            end
            default: ;
        endcase
        ans.mapped_page_count = shadow_pages;
        return ans;
    endfunction

    function automatic logic [GA_W-1:0] rand_ga();
        return GA_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [HA_W-1:0] rand_ha();
        return HA_W'({$urandom(), $urandom()});
    endfunction

    // Decide whether an idle burst starts now: mode 0 never, 1 light, 2 heavy
    function automatic bit start_gap(int unsigned mode);
        if (mode == 1)
            return $urandom_range(0, 7) == 0;
        if (mode == 2)
            return $urandom_range(0, 1) == 0;
        return 1'b0;
    endfunction

    task automatic queue_cmd(t_cmd c, logic [GA_W-1:0] ga, logic [HA_W-1:0] ha,
                             logic [FL_W-1:0] fl, bit drain);
        t_page_cmd pc;
        pc.command     = c;
        pc.guest       = ga;
        pc.host        = ha;
        pc.flags       = fl;
        pc.drain_first = drain;
        cmd_backlog.push_back(pc);
        if (c == CMD_MAP && ga[OFF_W-1:0] == '0)
            known_pages.push_back(ga);
    endtask

    // Mostly known pages and their leaf-table neighbors, some fresh addresses
    task automatic queue_random_cmd(bit drain);
        int unsigned     pick;
        t_cmd            c;
        logic [GA_W-1:0] ga;
        logic [HA_W-1:0] ha;
        logic [FL_W-1:0] fl;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = CMD_MAP;
        else if (pick < 65)
            c = CMD_UNMAP;
        else if (pick < 97)
            c = CMD_LOOKUP;
        else
            c = CMD_RSVD;
        ha = rand_ha();
        fl = FL_W'($urandom());
        if ($urandom_range(0, 9) != 0) begin
            ha[OFF_W-1:0] = '0;
            fl[0] = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            ga = known_pages[$urandom_range(0, known_pages.size() - 1)];
        end else if (pick < 8) begin
            ga = known_pages[$urandom_range(0, known_pages.size() - 1)];
            ga[OFF_W +: IDX_W] = IDX_W'($urandom());
        end else begin
            ga = rand_ga();
        end
        if (c != CMD_MAP)
            ga[OFF_W-1:0] = OFF_W'($urandom());
        else if ($urandom_range(0, 9) != 0)
            ga[OFF_W-1:0] = '0;
        else
            ga[OFF_W-1:0] = OFF_W'($urandom());
        queue_cmd(c, ga, ha, fl, drain);
    endtask

    // Stop a hung run
    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check response items against the oldest answer owed, then predict new commands
    always @(posedge i_clk) begin : sample_ports
        t_rsp      want;
        t_page_cmd seen;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (answers_due.size() == 0) begin
                    $error("response item with no command outstanding");
                    miscompare_cnt++;
                end else begin
                    want = answers_due.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        miscompare_cnt++;
                    end
                    if (rsp_if.translated_address !== want.translated_address) begin
                        $error("translated_address: expected %h, got %h",
                               want.translated_address, rsp_if.translated_address);
                        miscompare_cnt++;
                    end
                    if (rsp_if.was_mapped !== want.was_mapped) begin
                        $error("was_mapped: expected %0d, got %0d",
                               want.was_mapped, rsp_if.was_mapped);
                        miscompare_cnt++;
                    end
                    if (rsp_if.mapped_page_count !== want.mapped_page_count) begin
                        $error("mapped_page_count: expected %0d, got %0d",
                               want.mapped_page_count, rsp_if.mapped_page_count);
                        miscompare_cnt++;
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                seen.command     = t_cmd'(cmd_if.command);
                seen.guest       = cmd_if.guest_address;
                seen.host        = cmd_if.host_address;
                seen.flags       = cmd_if.entry_flags;
                seen.drain_first = 1'b0;
                answers_due.push_back(tree_answer(seen));
                cmds_taken++;
            end
        end
        cmd_took <= cmd_if.valid && cmd_if.ready;
    end

    // Offer command items from the backlog, with idle bursts and drain points
    always @(negedge i_clk) begin : drive_cmds
        bit        show;
        t_page_cmd pc;
        if (cycle_cnt % 64 == 0)
            tx_mode = $urandom_range(0, 2);
        show = cmd_if.valid && !cmd_took;
        if (i_rst_n && !show) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (cmd_backlog.size() > 0) begin
                // a drain point waits until every answer owed has come back
                if (!(cmd_backlog[0].drain_first && answers_due.size() != 0)) begin
                    if (cmd_backlog.size() > TAIL_QUIET && start_gap(tx_mode)) begin
                        tx_gap = $urandom_range(1, 17) - 1;
                    end else begin
                        pc = cmd_backlog.pop_front();
                        cmd_if.command       <= pc.command;
                        cmd_if.guest_address <= pc.guest;
                        cmd_if.host_address  <= pc.host;
                        cmd_if.entry_flags   <= pc.flags;
                        show = 1'b1;
                    end
                end
            end
        end
        cmd_if.valid <= show;
    end

    // Drive response ready: random idle bursts and one long hold-off
    always @(negedge i_clk) begin : drive_ready
        bit take;
        if (cycle_cnt % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        take = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && cmds_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end else if (rx_gap > 0) begin
            rx_gap--;
        end else if (cmd_backlog.size() > TAIL_QUIET && start_gap(rx_mode)) begin
            rx_gap = $urandom_range(1, 17) - 1;
        end else begin
            take = 1'b1;
        end
        rsp_if.ready <= take;
    end

    initial begin : stimulus
        logic [GA_W-1:0] ga;
        logic [HA_W-1:0] ha;
        logic [IDX_W-1:0] root;
        bit              root_taken [int unsigned];

        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_MAP;
        cmd_if.guest_address = '0;
        cmd_if.host_address  = '0;
        cmd_if.entry_flags   = '0;
        rsp_if.ready         = 1'b0;
        i_rst_n              = 1'b0;

        // Empty tree, first map, overwrite, offsets, alignment and flag checks
        queue_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0);
        queue_cmd(CMD_UNMAP, 48'h0000_0000_0abc, '0, '0, 1'b0);
        queue_cmd(CMD_MAP, '0, '0, 12'h001, 1'b0);
        queue_cmd(CMD_LOOKUP, 48'h0000_0000_0fff, rand_ha(), 12'hfff, 1'b0);
        queue_cmd(CMD_MAP, '0, 52'hf_ffff_ffff_f000, 12'hfff, 1'b0);
        queue_cmd(CMD_LOOKUP, 48'h0000_0000_0123, '0, '0, 1'b0);
        queue_cmd(CMD_MAP, 48'hffff_ffff_f000, 52'h0_0000_0000_1000, 12'h007, 1'b0);
        queue_cmd(CMD_LOOKUP, 48'hffff_ffff_ffff, '0, '0, 1'b0);
        queue_cmd(CMD_MAP, 48'h0000_4000_0000, 52'h0_0000_0000_2000, 12'h003, 1'b0);
        queue_cmd(CMD_MAP, 48'h0000_0000_0001, 52'h0_0000_0000_3000, 12'h001, 1'b0);
        queue_cmd(CMD_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_3800, 12'h001, 1'b0);
        queue_cmd(CMD_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_3000, 12'hffe, 1'b0);
        queue_cmd(CMD_RSVD, rand_ga(), rand_ha(), FL_W'($urandom()), 1'b0);
        queue_cmd(CMD_LOOKUP, 48'h0000_0000_1000, '0, '0, 1'b0);
        queue_cmd(CMD_MAP, 48'h0000_0000_1000, 52'h0_0000_0000_4000, 12'h005, 1'b0);
        queue_cmd(CMD_UNMAP, 48'h0000_0000_0abc, '0, '0, 1'b0);
        queue_cmd(CMD_UNMAP, '0, '0, '0, 1'b0);
        queue_cmd(CMD_LOOKUP, 48'h0000_0000_07ff, '0, '0, 1'b0);
        queue_cmd(CMD_LOOKUP, 48'h0000_0000_1fff, '0, '0, 1'b0);
        queue_cmd(CMD_UNMAP, 48'hffff_ffff_ffff, '0, '0, 1'b0);
        queue_cmd(CMD_LOOKUP, 48'h8000_0000_0000, '0, '0, 1'b0);

        // Maps under fresh root slots: run the pool dry, one part way, the rest with none left
        root_taken[0]   = 1'b1;
        root_taken[511] = 1'b1;
        for (int n = 0; n < FILL_MAPS; n++) begin
            do
                root = IDX_W'($urandom());
            while (root_taken.exists(root));
            root_taken[root] = 1'b1;
            ga = rand_ga();
            ga[GA_W-1 -: IDX_W] = root;
            ga[OFF_W-1:0] = '0;
            ha = rand_ha();
            ha[OFF_W-1:0] = '0;
            queue_cmd(CMD_MAP, ga, ha, FL_W'($urandom()) | 12'h001, n == 0);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
            queue_random_cmd(n == DRAIN_AT);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_if.valid)
            @(negedge i_clk);
        while (answers_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (miscompare_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== ept_four_level_map_unmap_lookup.f =====
rtl/core/eptl_pkg.sv
rtl/core/eptl_if.sv
rtl/core/eptl_table_ram.sv
rtl/core/eptl_walker.sv
rtl/core/ept_four_level_map_unmap_lookup.sv
sim/tb_top.sv
